/* hw/rtl/obgf_pkg.sv */
// Shared types and constants for the oriented box ground footprint core.
package obgf_pkg;

  localparam int ROT_W   = 16;  // signed Q2.14 rotation entry
  localparam int EXT_W   = 24;  // unsigned extent / length
  localparam int MAG_W   = 16;  // |rot|, up to 32768
  localparam int PROD_W  = 40;  // |rot| * extent
  localparam int A_W     = 32;  // rounded axis magnitude
  localparam int SQ_W    = 64;  // ax^2 + ay^2
  localparam int LEN_W   = 32;  // floor sqrt
  localparam int NUM_W   = 47;  // (a << 14) + len/2
  localparam int Q_W     = 16;  // direction quotient
  localparam int HSUM_W  = 42;  // sum of three z products
  localparam int HH_W    = 26;
  localparam int LIM_W   = 8;
  localparam int DIR_W   = 16;
  localparam int ROT_FRAC  = 14;
  localparam int PRE_SHIFT = 8;
  localparam int LEN_EXTRA = ROT_FRAC - PRE_SHIFT;
  localparam int SQRT_STEPS = LEN_W;
  localparam int DIV_STEPS  = Q_W;

  localparam logic [Q_W-1:0]   ONE_Q14    = 16'd16384;
  localparam logic [EXT_W-1:0] LEN_MAX    = 24'd16777215;
  localparam logic [HH_W-1:0]  HEIGHT_MAX = 26'd50331645;

  typedef struct packed {
    logic signed [ROT_W-1:0] rot_00;
    logic signed [ROT_W-1:0] rot_01;
    logic signed [ROT_W-1:0] rot_02;
    logic signed [ROT_W-1:0] rot_10;
    logic signed [ROT_W-1:0] rot_11;
    logic signed [ROT_W-1:0] rot_12;
    logic signed [ROT_W-1:0] rot_20;
    logic signed [ROT_W-1:0] rot_21;
    logic signed [ROT_W-1:0] rot_22;
    logic [EXT_W-1:0] extent_x;
    logic [EXT_W-1:0] extent_y;
    logic [EXT_W-1:0] extent_z;
  } in_req_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic [EXT_W-1:0] half_length;
    logic [EXT_W-1:0] half_width;
    logic [HH_W-1:0]  half_height;
  } out_res_t;

  // what one lane carries alongside its square root
  typedef struct packed {
    logic [A_W-1:0]    ax;
    logic [A_W-1:0]    ay;
    logic              negx;
    logic              negy;
    logic [PROD_W-1:0] mz;
  } lane_side_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    lane_side_t        side;
  } lane_res_t;

  // merged fields that ride along the divider
  typedef struct packed {
    logic [EXT_W-1:0] hl;
    logic [EXT_W-1:0] wl;
    logic [HH_W-1:0]  hh;
    logic             negx;
    logic             negy;
    logic             use_dir;
    logic             zero_len;
  } merge_side_t;

endpackage

/* hw/rtl/obgf_lane.sv */
// One axis lane: scaled magnitudes, squared ground length, pipelined sqrt.
module obgf_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [obgf_pkg::ROT_W-1:0] rot_x,
  input  logic signed [obgf_pkg::ROT_W-1:0] rot_y,
  input  logic signed [obgf_pkg::ROT_W-1:0] rot_z,
  input  logic [obgf_pkg::EXT_W-1:0]     ext,
  output logic                           out_vld,
  output obgf_pkg::lane_res_t            res
);
  import obgf_pkg::*;

  logic [MAG_W-1:0]  magx, magy, magz;
  logic [PROD_W-1:0] mx_r, my_r, mz1_r;
  logic              nx1_r, ny1_r, v1_r;
  logic [A_W-1:0]    ax_nxt, ay_nxt, ax2_r, ay2_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [PROD_W-1:0] mz2_r;
  logic              nx2_r, ny2_r, v2_r;
  logic [SQ_W-1:0]   s_r;
  lane_side_t        sd3_r;
  logic              v3_r;

  logic [SQ_W-1:0]   rem_r [0:SQRT_STEPS];
  logic [SQ_W-1:0]   root_r [0:SQRT_STEPS];
  lane_side_t        sd_r [0:SQRT_STEPS];
  logic              vld_r [0:SQRT_STEPS];

  assign magx = rot_x[ROT_W-1] ? MAG_W'(-rot_x) : MAG_W'(rot_x);
  assign magy = rot_y[ROT_W-1] ? MAG_W'(-rot_y) : MAG_W'(rot_y);
  assign magz = rot_z[ROT_W-1] ? MAG_W'(-rot_z) : MAG_W'(rot_z);

  // stage 1: products
  always_ff @(posedge clk) begin
    mx_r  <= PROD_W'(magx) * PROD_W'(ext);
    my_r  <= PROD_W'(magy) * PROD_W'(ext);
    mz1_r <= PROD_W'(magz) * PROD_W'(ext);
    nx1_r <= rot_x[ROT_W-1];
    ny1_r <= rot_y[ROT_W-1];
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_vld;
  end

  // stage 2: round half up, square
  assign ax_nxt = A_W'((mx_r + PROD_W'(1 << (PRE_SHIFT - 1))) >> PRE_SHIFT);
  assign ay_nxt = A_W'((my_r + PROD_W'(1 << (PRE_SHIFT - 1))) >> PRE_SHIFT);

  always_ff @(posedge clk) begin
    ax2_r <= ax_nxt;
    ay2_r <= ay_nxt;
    sqx_r <= SQ_W'(ax_nxt) * SQ_W'(ax_nxt);
    sqy_r <= SQ_W'(ay_nxt) * SQ_W'(ay_nxt);
    mz2_r <= mz1_r;
    nx2_r <= nx1_r;
    ny2_r <= ny1_r;
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    s_r <= sqx_r + sqy_r;
    sd3_r.ax <= ax2_r;
    sd3_r.ay <= ay2_r;
    sd3_r.negx <= nx2_r;
    sd3_r.negy <= ny2_r;
    sd3_r.mz <= mz2_r;
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
  end

  assign rem_r[0]  = s_r;
  assign root_r[0] = '0;
  assign sd_r[0]   = sd3_r;
  assign vld_r[0]  = v3_r;

  // digit-by-digit square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQ_W-1:0] bit_w, trial;
    assign bit_w = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    assign trial = root_r[k] + bit_w;
    always_ff @(posedge clk) begin
      if (rem_r[k] >= trial) begin
        rem_r[k+1]  <= rem_r[k] - trial;
        root_r[k+1] <= (root_r[k] >> 1) + bit_w;
      end else begin
        rem_r[k+1]  <= rem_r[k];
        root_r[k+1] <= root_r[k] >> 1;
      end
      sd_r[k+1] <= sd_r[k];
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else vld_r[k+1] <= vld_r[k];
    end
  end

  assign res.len  = root_r[SQRT_STEPS][LEN_W-1:0];
  assign res.side = sd_r[SQRT_STEPS];
  assign out_vld  = vld_r[SQRT_STEPS];

endmodule

/* hw/rtl/obgf_div.sv */
// Pipelined restoring divider: two numerators over one shared divisor.
module obgf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [obgf_pkg::NUM_W-1:0]  num_x,
  input  logic [obgf_pkg::NUM_W-1:0]  num_y,
  input  logic [obgf_pkg::LEN_W-1:0]  den,
  input  obgf_pkg::merge_side_t       side_in,
  output logic                        out_vld,
  output logic [obgf_pkg::Q_W-1:0]    q_x,
  output logic [obgf_pkg::Q_W-1:0]    q_y,
  output obgf_pkg::merge_side_t       side_out
);
  import obgf_pkg::*;

  logic [NUM_W-1:0] rx_r [0:DIV_STEPS];
  logic [NUM_W-1:0] ry_r [0:DIV_STEPS];
  logic [Q_W-1:0]   qx_r [0:DIV_STEPS];
  logic [Q_W-1:0]   qy_r [0:DIV_STEPS];
  logic [LEN_W-1:0] d_r  [0:DIV_STEPS];
  merge_side_t      sd_r [0:DIV_STEPS];
  logic             vld_r [0:DIV_STEPS];

  assign rx_r[0]  = num_x;
  assign ry_r[0]  = num_y;
  assign qx_r[0]  = '0;
  assign qy_r[0]  = '0;
  assign d_r[0]   = den;
  assign sd_r[0]  = side_in;
  assign vld_r[0] = in_vld;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [NUM_W:0] ds;
    logic           gx, gy;
    assign ds = (NUM_W+1)'(d_r[k]) << (DIV_STEPS - 1 - k);
    assign gx = {1'b0, rx_r[k]} >= ds;
    assign gy = {1'b0, ry_r[k]} >= ds;
    always_ff @(posedge clk) begin
      rx_r[k+1] <= gx ? rx_r[k] - ds[NUM_W-1:0] : rx_r[k];
      ry_r[k+1] <= gy ? ry_r[k] - ds[NUM_W-1:0] : ry_r[k];
      qx_r[k+1] <= {qx_r[k][Q_W-2:0], gx};
      qy_r[k+1] <= {qy_r[k][Q_W-2:0], gy};
      d_r[k+1]  <= d_r[k];
      sd_r[k+1] <= sd_r[k];
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else vld_r[k+1] <= vld_r[k];
    end
  end

  assign q_x      = qx_r[DIV_STEPS];
  assign q_y      = qy_r[DIV_STEPS];
  assign side_out = sd_r[DIV_STEPS];
  assign out_vld  = vld_r[DIV_STEPS];

endmodule

/* hw/rtl/oriented_box_ground_footprint_core.sv */
// Top level: three axis lanes, merge stage, direction divider, result register.
//
// Takes one oriented box per clock and returns its ground footprint: half
// length and unit direction of the longest ground-projected axis, half width
// and half height. busy is always low, so a request may be issued every
// cycle; each result appears on out_res for exactly one cycle with
// out_strobe high, in request order, after 3 product and square stages,
// 32 square-root stages, 1 merge stage, 16 divider stages and 1 output
// stage. The depth is set by the per-bit square root and the per-bit
// divider. The receiver cannot stall the output; results are never held.
// The degenerate limit register may be written at any time through
// cfg_valid/cfg_ready (always ready) and takes effect at the merge stage,
// so write it only while no request is in flight.
module oriented_box_ground_footprint_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  obgf_pkg::in_req_t             in_req,
  output logic                          out_strobe,
  output obgf_pkg::out_res_t            out_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [obgf_pkg::LIM_W-1:0]    cfg_data
);
  import obgf_pkg::*;

  logic [LIM_W-1:0] limit_r;
  logic             acc;
  logic [2:0]       lane_vld;
  lane_res_t        lane [0:2];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= '0;
    else if (cfg_valid && cfg_ready) limit_r <= cfg_data;
  end

  // lane i handles matrix column i scaled by extent i
  obgf_lane u_lane0 (
    .clk, .rst_n, .in_vld(acc),
    .rot_x(in_req.rot_00), .rot_y(in_req.rot_10), .rot_z(in_req.rot_20),
    .ext(in_req.extent_x), .out_vld(lane_vld[0]), .res(lane[0]));
  obgf_lane u_lane1 (
    .clk, .rst_n, .in_vld(acc),
    .rot_x(in_req.rot_01), .rot_y(in_req.rot_11), .rot_z(in_req.rot_21),
    .ext(in_req.extent_y), .out_vld(lane_vld[1]), .res(lane[1]));
  obgf_lane u_lane2 (
    .clk, .rst_n, .in_vld(acc),
    .rot_x(in_req.rot_02), .rot_y(in_req.rot_12), .rot_z(in_req.rot_22),
    .ext(in_req.extent_z), .out_vld(lane_vld[2]), .res(lane[2]));

  // ---- merge: longest axis (lowest index wins ties), width, height ----
  logic [1:0]        sel01, longest;
  logic [LEN_W-1:0]  len01, len_l, len_w;
  logic [HSUM_W-1:0] hsum;
  logic [HSUM_W-1:0] hh_full;
  logic [LEN_W-1:0]  hl_rnd, wl_rnd;
  lane_side_t        sd_l;
  merge_side_t       m_nxt, m_side_r;
  logic [NUM_W-1:0]  nx_r, ny_r;
  logic [LEN_W-1:0]  den_r;
  logic              m_vld_r;

  always_comb begin
    sel01 = (lane[1].len > lane[0].len) ? 2'd1 : 2'd0;
    len01 = (lane[1].len > lane[0].len) ? lane[1].len : lane[0].len;
    longest = (lane[2].len > len01) ? 2'd2 : sel01;
    unique case (longest)
      2'd1: begin
        len_l = lane[1].len;
        sd_l  = lane[1].side;
        len_w = (lane[2].len > lane[0].len) ? lane[2].len : lane[0].len;
      end
      2'd2: begin
        len_l = lane[2].len;
        sd_l  = lane[2].side;
        len_w = (lane[1].len > lane[0].len) ? lane[1].len : lane[0].len;
      end
      default: begin
        len_l = lane[0].len;
        sd_l  = lane[0].side;
        len_w = (lane[2].len > lane[1].len) ? lane[2].len : lane[1].len;
      end
    endcase
    hsum = HSUM_W'(lane[0].side.mz) + HSUM_W'(lane[1].side.mz)
         + HSUM_W'(lane[2].side.mz);
    hh_full = (hsum + HSUM_W'(1 << (ROT_FRAC - 1))) >> ROT_FRAC;
    // len < 2^32 so the rounded value fits in 32 bits
    hl_rnd = LEN_W'(({1'b0, len_l} + 33'(1 << (LEN_EXTRA - 1))) >> LEN_EXTRA);
    wl_rnd = LEN_W'(({1'b0, len_w} + 33'(1 << (LEN_EXTRA - 1))) >> LEN_EXTRA);
    m_nxt.hl = (hl_rnd > LEN_W'(LEN_MAX)) ? LEN_MAX : hl_rnd[EXT_W-1:0];
    m_nxt.wl = (wl_rnd > LEN_W'(LEN_MAX)) ? LEN_MAX : wl_rnd[EXT_W-1:0];
    m_nxt.hh = (hh_full > HSUM_W'(HEIGHT_MAX)) ? HEIGHT_MAX : hh_full[HH_W-1:0];
    m_nxt.negx = sd_l.negx;
    m_nxt.negy = sd_l.negy;
    m_nxt.use_dir = m_nxt.hl > EXT_W'(limit_r);
    m_nxt.zero_len = (len_l == '0);
  end

  always_ff @(posedge clk) begin
    m_side_r <= m_nxt;
    nx_r  <= (NUM_W'(sd_l.ax) << ROT_FRAC) + NUM_W'(len_l >> 1);
    ny_r  <= (NUM_W'(sd_l.ay) << ROT_FRAC) + NUM_W'(len_l >> 1);
    den_r <= len_l;
    if (!rst_n) m_vld_r <= 1'b0;
    else m_vld_r <= &lane_vld;
  end

  // ---- direction: round(a * 16384 / len) ----
  logic             d_vld;
  logic [Q_W-1:0]   qx, qy, mx, my;
  merge_side_t      d_side;
  out_res_t         res_nxt;

  obgf_div u_div (
    .clk, .rst_n, .in_vld(m_vld_r),
    .num_x(nx_r), .num_y(ny_r), .den(den_r), .side_in(m_side_r),
    .out_vld(d_vld), .q_x(qx), .q_y(qy), .side_out(d_side));

  always_comb begin
    mx = d_side.zero_len ? '0 : ((qx > ONE_Q14) ? ONE_Q14 : qx);
    my = d_side.zero_len ? '0 : ((qy > ONE_Q14) ? ONE_Q14 : qy);
    if (d_side.use_dir) begin
      res_nxt.dir_x = d_side.negx ? DIR_W'(-mx) : DIR_W'(mx);
      res_nxt.dir_y = d_side.negy ? DIR_W'(-my) : DIR_W'(my);
    end else begin
      res_nxt.dir_x = DIR_W'(ONE_Q14);
      res_nxt.dir_y = '0;
    end
    res_nxt.half_length = d_side.hl;
    res_nxt.half_width  = d_side.wl;
    res_nxt.half_height = d_side.hh;
  end

  always_ff @(posedge clk) begin
    out_res <= res_nxt;
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= d_vld;
  end

endmodule

/* verif/oriented_box_ground_footprint_core_tb.sv */
// Testbench for the oriented box ground footprint core: directed and random boxes, scoreboard.
`timescale 1ns / 1ps
module oriented_box_ground_footprint_core_tb;
  import obgf_pkg::*;

  localparam int LATENCY = 53;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_strobe;
  out_res_t out_res;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [LIM_W-1:0] cfg_data;

  oriented_box_ground_footprint_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor's copy of the degenerate limit, updated on each accepted write.
  logic [LIM_W-1:0] limit_q;

  in_req_t  box_queue[$];      // requests not yet issued
  out_res_t footprint_q[$];    // predicted footprints, oldest first
  int       gap_left;
  int       fail_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rounds an internal length (6 extra fraction bits) to extent format, saturating.
  function automatic logic [EXT_W-1:0] len_to_ext(input logic [63:0] len);
    logic [63:0] v;
    v = (len + 64'd32) >> LEN_EXTRA;
    return (v > LEN_MAX) ? LEN_MAX : v[EXT_W-1:0];
  endfunction

  function automatic logic [63:0] unit_mag(input logic [63:0] a, input logic [63:0] len);
    logic [63:0] q;
    if (len == 0) return 0;
    q = ((a << ROT_FRAC) + (len >> 1)) / len;
    return (q > 64'd16384) ? 64'd16384 : q;
  endfunction

  function automatic out_res_t footprint_of(input in_req_t b, input logic [LIM_W-1:0] lim);
    logic signed [15:0] rx[3], ry[3], rz[3];
    logic [23:0] ext[3];
    logic [63:0] ax[3], ay[3], len[3];
    logic [63:0] hsum, hh, wl_raw, mx, my;
    int lng;
    out_res_t r;
    rx = '{b.rot_00, b.rot_01, b.rot_02};
    ry = '{b.rot_10, b.rot_11, b.rot_12};
    rz = '{b.rot_20, b.rot_21, b.rot_22};
    ext = '{b.extent_x, b.extent_y, b.extent_z};
    hsum = 0;
    lng = 0;
    for (int i = 0; i < 3; i++) begin
      ax[i] = (64'(rx[i] < 0 ? -32'(rx[i]) : 32'(rx[i])) * ext[i] + 128) >> PRE_SHIFT;
      ay[i] = (64'(ry[i] < 0 ? -32'(ry[i]) : 32'(ry[i])) * ext[i] + 128) >> PRE_SHIFT;
      hsum += 64'(rz[i] < 0 ? -32'(rz[i]) : 32'(rz[i])) * ext[i];
      len[i] = isqrt(ax[i] * ax[i] + ay[i] * ay[i]);
      if (len[i] > len[lng]) lng = i;  // ties keep the lower axis
    end
    wl_raw = 0;
    for (int i = 0; i < 3; i++)
      if (i != lng && len[i] > wl_raw) wl_raw = len[i];
    hh = (hsum + 64'd8192) >> ROT_FRAC;
    r.half_length = len_to_ext(len[lng]);
    r.half_width  = len_to_ext(wl_raw);
    r.half_height = (hh > HEIGHT_MAX) ? HEIGHT_MAX : hh[HH_W-1:0];
    if (r.half_length > lim) begin
      mx = unit_mag(ax[lng], len[lng]);
      my = unit_mag(ay[lng], len[lng]);
      r.dir_x = (rx[lng] < 0) ? -16'(mx) : 16'(mx);
      r.dir_y = (ry[lng] < 0) ? -16'(my) : 16'(my);
    end else begin
      r.dir_x = 16'sd16384;  // degenerate footprint: default direction
      r.dir_y = 16'sd0;
    end
    return r;
  endfunction

  // Driver: issues queued requests with random gaps, mostly short, some long.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        footprint_q.push_back(footprint_of(in_req, limit_q));
      if (start && busy) begin
        // hold the request
      end else if (gap_left > 0 || box_queue.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        start  <= 1'b1;
        in_req <= box_queue.pop_front();
        case ($urandom_range(0, 9))
          0, 1:    gap_left <= $urandom_range(1, 3);
          2:       gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 70) : 0;
          default: gap_left <= 0;
        endcase
      end
    end
  end

  // Monitor: compares each strobed footprint with the oldest prediction.
  always @(posedge clk) begin
    out_res_t exp_r;
    if (rst_n && out_strobe) begin
      if (footprint_q.size() == 0) begin
        $error("footprint with no request outstanding");
        fail_count++;
      end else begin
        exp_r = footprint_q.pop_front();
        if (out_res.dir_x !== exp_r.dir_x) begin
          $error("dir_x exp %0d got %0d", exp_r.dir_x, out_res.dir_x); fail_count++;
        end
        if (out_res.dir_y !== exp_r.dir_y) begin
          $error("dir_y exp %0d got %0d", exp_r.dir_y, out_res.dir_y); fail_count++;
        end
        if (out_res.half_length !== exp_r.half_length) begin
          $error("half_length exp %0d got %0d", exp_r.half_length, out_res.half_length);
          fail_count++;
        end
        if (out_res.half_width !== exp_r.half_width) begin
          $error("half_width exp %0d got %0d", exp_r.half_width, out_res.half_width);
          fail_count++;
        end
        if (out_res.half_height !== exp_r.half_height) begin
          $error("half_height exp %0d got %0d", exp_r.half_height, out_res.half_height);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_rot();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);  // out of range, any 16-bit value
      1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [23:0] rand_ext();
    case ($urandom_range(0, 7))
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(0, 255));
      2:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
      default: return 24'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  function automatic in_req_t rand_box();
    in_req_t b;
    int ang;
    real c, s;
    b.rot_00 = rand_rot(); b.rot_01 = rand_rot(); b.rot_02 = rand_rot();
    b.rot_10 = rand_rot(); b.rot_11 = rand_rot(); b.rot_12 = rand_rot();
    b.rot_20 = rand_rot(); b.rot_21 = rand_rot(); b.rot_22 = rand_rot();
    if ($urandom_range(0, 1)) begin
      // proper yaw rotation, the common real case
      ang = $urandom_range(0, 3599);
      c = $cos(ang * 3.14159265 / 1800.0);
      s = $sin(ang * 3.14159265 / 1800.0);
      b.rot_00 = 16'($rtoi(c * 16384.0)); b.rot_01 = 16'($rtoi(-s * 16384.0));
      b.rot_10 = 16'($rtoi(s * 16384.0)); b.rot_11 = 16'($rtoi(c * 16384.0));
      b.rot_02 = 0; b.rot_12 = 0; b.rot_20 = 0; b.rot_21 = 0; b.rot_22 = 16'sd16384;
    end
    b.extent_x = rand_ext(); b.extent_y = rand_ext(); b.extent_z = rand_ext();
    return b;
  endfunction

  function automatic in_req_t make_box(input logic signed [15:0] r0, r1, r2, r3, r4, r5,
                                       r6, r7, r8, input logic [23:0] ex, ey, ez);
    in_req_t b;
    b.rot_00 = r0; b.rot_01 = r1; b.rot_02 = r2;
    b.rot_10 = r3; b.rot_11 = r4; b.rot_12 = r5;
    b.rot_20 = r6; b.rot_21 = r7; b.rot_22 = r8;
    b.extent_x = ex; b.extent_y = ey; b.extent_z = ez;
    return b;
  endfunction

  // Waits for all footprints to come back, then lets the pipeline drain.
  task automatic drain();
    while (box_queue.size() != 0 || start || footprint_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_q   <= v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  localparam logic signed [15:0] P1 = 16'sd16384;
  localparam logic signed [15:0] N1 = -16'sd16384;

  initial begin
    logic [LIM_W-1:0] limits[5];
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    limit_q = '0;
    fail_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero box, extremes, ties, degenerate, out of range.
    box_queue.push_back(make_box(P1, 0, 0, 0, P1, 0, 0, 0, P1, 24'd256, 24'd512, 24'd768));
    box_queue.push_back(make_box(P1, 0, 0, 0, P1, 0, 0, 0, P1, 0, 0, 0));
    box_queue.push_back(make_box(P1, 0, 0, 0, P1, 0, 0, 0, P1, '1, '1, '1));
    box_queue.push_back(make_box(N1, N1, N1, N1, N1, N1, N1, N1, N1, '1, '1, '1));
    box_queue.push_back(make_box(0, P1, 0, P1, 0, 0, 0, 0, P1, 24'd1000, 24'd1000, 24'd5));
    box_queue.push_back(make_box(P1, P1, P1, 0, 0, 0, 0, 0, 0, 24'd77, 24'd77, 24'd77));
    box_queue.push_back(make_box(-16'sd32768, 16'sd32767, 16'sh7FFF, -16'sd32768, 16'sd1, -16'sd1,
                                 16'sh7FFF, -16'sd32768, 16'sd32767, '1, '1, '1));
    box_queue.push_back(make_box(16'sd11585, -16'sd11585, 0, -16'sd11585, -16'sd11585, 0,
                                 0, 0, P1, 24'd40000, 24'd300, 24'd1));
    box_queue.push_back(make_box(1, 0, 0, 0, 1, 0, 0, 0, 1, 24'd1, 24'd1, 24'd1));
    box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, P1, P1, P1, 24'hAAAAAA, 24'h555555, 24'd9));
    box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h123456, 24'd0, 24'hFFFFFF));
    drain();

    // Random phases across limit settings, extremes included.
    limits = '{8'd0, 8'd255, 8'd1, 8'd128, 8'($urandom_range(0, 255))};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      repeat (300) box_queue.push_back(rand_box());
      // a few small boxes so the limit actually bites
      repeat (80) box_queue.push_back(make_box(rand_rot(), rand_rot(), rand_rot(), rand_rot(),
          rand_rot(), rand_rot(), rand_rot(), rand_rot(), rand_rot(),
          24'($urandom_range(0, 300)), 24'($urandom_range(0, 300)),
          24'($urandom_range(0, 300))));
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
